// ===== design/arc_pkg.sv =====
// arc_pkg: types, sizes and codes shared by the ASCII radix converter
// depends on nothing; compiled first

package arc_pkg;

   // value width and derived sizes
   localparam int VALUE_WIDTH = 32;
   localparam int BCD_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
   localparam int SR_WIDTH    = BCD_DIGITS * 4;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_WIDTH   = $clog2(VALUE_WIDTH);

   // ascii offsets
   localparam logic [7:0] ASCII_ZERO        = 8'd48;
   localparam logic [7:0] ASCII_NINE        = 8'd57;
   localparam logic [7:0] HEX_LETTER_OFFSET = 8'd87;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // radix codes, also the command codes of the input item
   typedef enum logic [1:0] {
      RADIX_DEC    = 2'd0,
      RADIX_BIN    = 2'd1,
      RADIX_HEX    = 2'd2,
      RADIX_IGNORE = 2'd3
   } radix_type;

   // conversion sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_BCD,
      S_SKIP,
      S_EMIT
   } conv_state_type;

   // request from the accumulator to the conversion unit
   typedef struct packed {
      logic      go;
      value_type value;
      radix_type first;
      radix_type second;
   } start_type;

endpackage

// ===== design/arc_req_if.sv =====
// arc_req_if: input channel of the radix converter (one character per item)
// depends on nothing

interface arc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] digit_char;
   logic       is_last;

   modport source (output valid, command, digit_char, is_last, input ready);
   modport sink   (input valid, command, digit_char, is_last, output ready);
endinterface

// ===== design/arc_rsp_if.sv =====
// arc_rsp_if: result channel of the radix converter (one digit per item)
// depends on nothing

interface arc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic [1:0] out_radix;
   logic       end_of_repr;
   logic       end_of_run;

   modport source (output valid, out_char, out_radix, end_of_repr, end_of_run, input ready);
   modport sink   (input valid, out_char, out_radix, end_of_repr, end_of_run, output ready);
endinterface

// ===== design/arc_conv.sv =====
// arc_conv: sequencer around one shared shift register that builds BCD by
// double dabble, skips leading zeros and emits digits; uses arc_pkg, arc_rsp_if

module arc_conv import arc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  start_type       start,
   output logic            busy,
   arc_rsp_if.source       rsp_bus
);

   conv_state_type          state_ff, state_in;
   value_type               value_ff, value_in;
   logic [SR_WIDTH-1:0]     sr_ff, sr_in;
   logic [CNT_WIDTH-1:0]    rem_ff, rem_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   radix_type               radix_ff, radix_in;
   radix_type               second_radix_ff, second_radix_in;
   logic                    second_ff, second_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              out_char_ff, out_char_in;
   logic [1:0]              out_radix_ff, out_radix_in;
   logic                    end_of_repr_ff, end_of_repr_in;
   logic                    end_of_run_ff, end_of_run_in;

   logic [3:0]              top_digit;
   logic [SR_WIDTH-1:0]     sr_shifted;
   logic [SR_WIDTH-1:0]     sr_dabbled;
   logic [IDX_WIDTH-1:0]    bit_idx;
   logic                    emit_fire;
   logic                    last_digit;

   // digit register contents for the start of a hex or binary run
   function automatic logic [SR_WIDTH-1:0] load_sr(radix_type r, value_type v);
      logic [SR_WIDTH-1:0] ext;
      ext = SR_WIDTH'(v);
      if (r == RADIX_BIN) begin
         load_sr = ext << (SR_WIDTH - VALUE_WIDTH);
      end else begin
         load_sr = ext << (SR_WIDTH - HEX_DIGITS * 4);
      end
   endfunction

   function automatic logic [CNT_WIDTH-1:0] load_count(radix_type r);
      if (r == RADIX_BIN) begin
         load_count = CNT_WIDTH'(VALUE_WIDTH);
      end else begin
         load_count = CNT_WIDTH'(HEX_DIGITS);
      end
   endfunction

   function automatic logic [7:0] digit_to_ascii(logic [3:0] d);
      if (d < 4'd10) begin
         digit_to_ascii = ASCII_ZERO + {4'b0, d};
      end else begin
         digit_to_ascii = HEX_LETTER_OFFSET + {4'b0, d};
      end
   endfunction

   // shared shift unit: top digit, one-digit shift and dabble step
   always_comb begin
      logic [3:0] nib;
      logic [SR_WIDTH-1:0] adj;
      adj = '0;
      for (int k = 0; k < BCD_DIGITS; k++) begin
         nib = sr_ff[k*4 +: 4];
         adj[k*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
      bit_idx    = IDX_WIDTH'(VALUE_WIDTH - 1) - cnt_ff[IDX_WIDTH-1:0];
      sr_dabbled = {adj[SR_WIDTH-2:0], value_ff[bit_idx]};
      if (radix_ff == RADIX_BIN) begin
         top_digit  = {3'b000, sr_ff[SR_WIDTH-1]};
         sr_shifted = sr_ff << 1;
      end else begin
         top_digit  = sr_ff[SR_WIDTH-1 -: 4];
         sr_shifted = sr_ff << 4;
      end
   end

   assign emit_fire  = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_bus.ready);
   assign last_digit = (rem_ff == CNT_WIDTH'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start.go) begin
               state_in = (start.first == RADIX_DEC) ? S_BCD : S_SKIP;
            end
         end
         S_BCD: begin
            if (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            if (last_digit || top_digit != 4'd0) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_fire && last_digit) begin
               state_in = second_ff ? S_IDLE : S_SKIP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and result register
   always_comb begin
      value_in        = value_ff;
      sr_in           = sr_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      radix_in        = radix_ff;
      second_radix_in = second_radix_ff;
      second_in       = second_ff;
      out_char_in     = out_char_ff;
      out_radix_in    = out_radix_ff;
      end_of_repr_in  = end_of_repr_ff;
      end_of_run_in   = end_of_run_ff;
      rsp_valid_in    = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (start.go) begin
               value_in        = start.value;
               radix_in        = start.first;
               second_radix_in = start.second;
               second_in       = 1'b0;
               cnt_in          = '0;
               if (start.first == RADIX_DEC) begin
                  sr_in = '0;
               end else begin
                  sr_in  = load_sr(start.first, start.value);
                  rem_in = load_count(start.first);
               end
            end
         end
         S_BCD: begin
            sr_in  = sr_dabbled;
            cnt_in = cnt_ff + CNT_WIDTH'(1);
            rem_in = CNT_WIDTH'(BCD_DIGITS);
         end
         S_SKIP: begin
            if (!(last_digit || top_digit != 4'd0)) begin
               sr_in  = sr_shifted;
               rem_in = rem_ff - CNT_WIDTH'(1);
            end
         end
         S_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in   = 1'b1;
               out_char_in    = digit_to_ascii(top_digit);
               out_radix_in   = radix_ff;
               end_of_repr_in = last_digit;
               end_of_run_in  = last_digit && second_ff;
               sr_in          = sr_shifted;
               rem_in         = rem_ff - CNT_WIDTH'(1);
               if (last_digit && !second_ff) begin
                  radix_in  = second_radix_ff;
                  second_in = 1'b1;
                  sr_in     = load_sr(second_radix_ff, value_ff);
                  rem_in    = load_count(second_radix_ff);
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff        <= value_in;
      sr_ff           <= sr_in;
      rem_ff          <= rem_in;
      cnt_ff          <= cnt_in;
      radix_ff        <= radix_in;
      second_radix_ff <= second_radix_in;
      second_ff       <= second_in;
      out_char_ff     <= out_char_in;
      out_radix_ff    <= out_radix_in;
      end_of_repr_ff  <= end_of_repr_in;
      end_of_run_ff   <= end_of_run_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_char    = out_char_ff;
   assign rsp_bus.out_radix   = out_radix_ff;
   assign rsp_bus.end_of_repr = end_of_repr_ff;
   assign rsp_bus.end_of_run  = end_of_run_ff;

   // a new number only starts while the sequencer is free
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start.go |-> state_ff == S_IDLE)
      else $error("conversion started while busy");

   // digit count never runs out while scanning or emitting
   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SKIP || state_ff == S_EMIT) |-> rem_ff != '0)
      else $error("digit count reached zero during scan");

   // the final digit of the second run returns the sequencer to idle
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && last_digit && second_ff) |=> state_ff == S_IDLE)
      else $error("sequencer did not return to idle after last digit");

   // end of run is only flagged on the last digit of a representation
   a_run_repr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && end_of_run_ff) |-> end_of_repr_ff)
      else $error("end of run without end of representation");

   // decimal digits leave double dabble as valid BCD at the top
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SKIP && radix_ff == RADIX_DEC) |-> sr_ff[SR_WIDTH-1 -: 4] <= 4'd9)
      else $error("decimal digit out of range");

endmodule

// ===== design/ascii_radix_converter.sv =====
// ascii_radix_converter: top level; digit accumulator and hand-off to the
// conversion sequencer; uses arc_pkg, arc_req_if, arc_rsp_if, arc_conv
//
// Usage: req_bus carries one ASCII character per item, most significant
// first, with command giving its radix (decimal, binary, hex; code three
// ignores the character). Each character is folded into a 32-bit running
// value in the cycle it is accepted, so ordinary characters go in one per
// cycle. The character marked is_last triggers conversion (except with
// code three): hex then binary for decimal input, decimal then hex for
// binary input, decimal then binary for hex input, each without leading
// zeros, one digit per rsp_bus item. When a decimal form is produced,
// double dabble first runs over all 32 value bits; then each form is
// scanned over its digit positions (10 decimal, 8 hex, 32 binary). The
// sequencer holds req_bus.ready low for the whole conversion.
// rsp_bus has an output register: a stalled receiver freezes emission, and
// the next character is taken while the final digit still waits.
// Reset (synchronous) clears the running value and returns to idle.

module ascii_radix_converter import arc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   arc_req_if.sink   req_bus,
   arc_rsp_if.source rsp_bus
);

   value_type  acc_ff, acc_in;
   value_type  digit_val;
   value_type  scaled;
   value_type  acc_next;
   radix_type  cmd;
   logic       accept;
   logic       busy;
   start_type  start;

   assign cmd    = radix_type'(req_bus.command);
   assign accept = req_bus.valid && req_bus.ready;

   // digit value of the character and the scaled running value
   always_comb begin
      if (cmd == RADIX_HEX &&
          !(req_bus.digit_char >= ASCII_ZERO && req_bus.digit_char <= ASCII_NINE)) begin
         digit_val = value_type'(req_bus.digit_char) - value_type'(HEX_LETTER_OFFSET);
      end else begin
         digit_val = value_type'(req_bus.digit_char) - value_type'(ASCII_ZERO);
      end
      case (cmd)
         RADIX_DEC: scaled = (acc_ff << 3) + (acc_ff << 1);
         RADIX_BIN: scaled = acc_ff << 1;
         RADIX_HEX: scaled = acc_ff << 4;
         default:   scaled = acc_ff;
      endcase
      acc_next = (cmd == RADIX_IGNORE) ? acc_ff : scaled + digit_val;
   end

   // accumulator update and start of conversion
   always_comb begin
      acc_in       = acc_ff;
      start.go     = 1'b0;
      start.value  = acc_next;
      start.first  = (cmd == RADIX_DEC) ? RADIX_HEX : RADIX_DEC;
      start.second = (cmd == RADIX_BIN) ? RADIX_HEX : RADIX_BIN;
      if (accept) begin
         if (req_bus.is_last) begin
            acc_in   = '0;
            start.go = (cmd != RADIX_IGNORE);
         end else begin
            acc_in = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign req_bus.ready = !busy;

   arc_conv u_conv (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .rsp_bus (rsp_bus)
   );

endmodule
